@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL of the phase derivative unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kpd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kpd assertion failed");

`endif

@@ rtl/kpd_pkg.sv @@
// ---------------------------------------------------------------------------
// kpd_pkg
// Types, codes and the microcode table of the phase derivative unit.
// ---------------------------------------------------------------------------
package kpd_pkg;

  localparam int DEF_OSC_COUNT        = 64;
  localparam int DEF_PHASE_BITS       = 16;
  localparam int DEF_SINE_TABLE_DEPTH = 256;

  localparam int ACC_W = 48;

  typedef enum logic [1:0] {
    REQ_COUPLING = 2'd0,
    REQ_PHASE    = 2'd1,
    REQ_FREQ     = 2'd2,
    REQ_COMPUTE  = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         osc_index;
    logic [5:0]         col_index;
    logic [15:0]        phase_value;
    logic signed [15:0] coupling_value;
    logic signed [31:0] freq_value;
    logic               fixed_flag;
    logic signed [31:0] noise_value;
  } req_t;

  typedef struct packed {
    logic [5:0]         result_index;
    logic signed [47:0] phase_rate;
    logic               saturated;
  } res_t;

  // Sequencer steps.
  typedef enum logic [2:0] {
    STEP_IDLE     = 3'd0,
    STEP_FETCH    = 3'd1,
    STEP_LOAD     = 3'd2,
    STEP_LOOP     = 3'd3,
    STEP_DRAIN    = 3'd4,
    STEP_WAIT_OUT = 3'd5,
    STEP_EMIT     = 3'd6
  } step_t;

  // Jump conditions: when met, go to the target step; otherwise advance.
  typedef enum logic [2:0] {
    COND_NONE     = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NOT_GO   = 3'd2,
    COND_MORE_J   = 3'd3,
    COND_BUSY     = 3'd4,
    COND_OUT_FULL = 3'd5
  } cond_t;

  typedef struct packed {
    logic  accept_en;
    logic  fetch_row;
    logic  load_row;
    logic  issue;
    logic  load_out;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // Write and start strobes from the request transfer.
  typedef struct packed {
    logic wr_coup;
    logic wr_phase;
    logic wr_freq;
    logic start;
  } req_ctrl_t;

  typedef struct packed {
    logic more_j;
    logic busy;
  } dp_status_t;

  typedef struct packed {
    logic compute_go;
    logic more_j;
    logic busy;
    logic out_full;
  } seq_status_t;

  localparam ctrl_word_t CW_NOP = '{
    accept_en: 1'b0, fetch_row: 1'b0, load_row: 1'b0, issue: 1'b0,
    load_out: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE
  };

  // Microcode table, one control word per step.
  function automatic ctrl_word_t ucode_word(input step_t s);
    ctrl_word_t w;
    w = CW_NOP;
    case (s)
      STEP_IDLE: begin
        w.accept_en = 1'b1;
        w.cond      = COND_NOT_GO;
        w.target    = STEP_IDLE;
      end
      STEP_FETCH: begin
        w.fetch_row = 1'b1;
        w.cond      = COND_NONE;
      end
      STEP_LOAD: begin
        w.load_row = 1'b1;
        w.cond     = COND_NONE;
      end
      STEP_LOOP: begin
        w.issue  = 1'b1;
        w.cond   = COND_MORE_J;
        w.target = STEP_LOOP;
      end
      STEP_DRAIN: begin
        w.cond   = COND_BUSY;
        w.target = STEP_DRAIN;
      end
      STEP_WAIT_OUT: begin
        w.cond   = COND_OUT_FULL;
        w.target = STEP_WAIT_OUT;
      end
      STEP_EMIT: begin
        w.load_out = 1'b1;
        w.cond     = COND_ALWAYS;
        w.target   = STEP_IDLE;
      end
      default: w = CW_NOP;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/kpd_sine_rom.sv @@
// ---------------------------------------------------------------------------
// kpd_sine_rom
// Quarter-wave sine table in Q1.15 magnitude, registered read.
// ---------------------------------------------------------------------------
module kpd_sine_rom
  import kpd_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
  input  logic                                    clk,
  input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]   addr,
  output logic [14:0]                             mag
);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned DIV_TERMS [12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  // Taylor series in Q2.30, rounded to Q1.15 and clipped.
  function automatic logic [14:0] sine_entry(input int k);
    longint unsigned x;
    longint unsigned t;
    longint          s;
    longint          e;
    int              n;
    x = (HALF_PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
    t = x;
    s = longint'(x);
    for (n = 1; n <= 12; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / DIV_TERMS[n-1];
      if ((n % 2) == 1) s = s - longint'(t);
      else s = s + longint'(t);
    end
    if (s < 0) s = 0;
    e = (s * 32767 + (longint'(1) <<< 29)) >>> 30;
    if (e > 32767) e = 32767;
    return e[14:0];
  endfunction

  logic [14:0] rom [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [14:0] ENTRY = sine_entry(k);
    assign rom[k] = ENTRY;
  end

  always_ff @(posedge clk) begin
    mag <= rom[addr];
  end

endmodule

@@ rtl/kpd_sequencer.sv @@
// ---------------------------------------------------------------------------
// kpd_sequencer
// Step counter over the microcode table with conditional jumps.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kpd_sequencer
  import kpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  seq_status_t status,
  output ctrl_word_t  ctrl
);

  step_t upc;
  step_t upc_next;
  logic  cond_met;

  // Next step.
  always_comb begin
    case (ctrl.cond)
      COND_NONE:     cond_met = 1'b0;
      COND_ALWAYS:   cond_met = 1'b1;
      COND_NOT_GO:   cond_met = !status.compute_go;
      COND_MORE_J:   cond_met = status.more_j;
      COND_BUSY:     cond_met = status.busy;
      COND_OUT_FULL: cond_met = status.out_full;
      default:       cond_met = 1'b1;
    endcase
    upc_next = cond_met ? ctrl.target : step_t'(3'(upc) + 3'd1);
  end

  // Control word of the current step.
  always_comb begin
    ctrl = ucode_word(upc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  `ASSERT_NXT(a_loop_exit, clk, rst, ctrl.issue && !status.more_j, upc == STEP_DRAIN)

endmodule

@@ rtl/kpd_datapath.sv @@
// ---------------------------------------------------------------------------
// kpd_datapath
// Stores, coupling walk pipeline and saturating accumulator.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kpd_datapath
  import kpd_pkg::*;
#(
  parameter int OSC_COUNT        = DEF_OSC_COUNT,
  parameter int PHASE_BITS       = DEF_PHASE_BITS,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_word_t         ctrl,
  input  req_ctrl_t          rc,
  input  req_t               item,
  output dp_status_t         status,
  output logic signed [47:0] phase_rate,
  output logic               saturated
);

  localparam int AW  = $clog2(OSC_COUNT);
  localparam int CAW = $clog2(OSC_COUNT * OSC_COUNT);
  localparam int OW  = PHASE_BITS - 2;
  localparam int TW  = $clog2(SINE_TABLE_DEPTH + 1);

  logic [PHASE_BITS-1:0] phase_mem [OSC_COUNT];
  logic [32:0]           freq_mem  [OSC_COUNT];
  logic [15:0]           coup_mem  [OSC_COUNT * OSC_COUNT];

  logic [31:0]    osc_ext;
  logic [31:0]    col_ext;
  logic [AW-1:0]  row_a;
  logic [AW-1:0]  col_a;
  logic [CAW-1:0] row_base;
  logic [CAW-1:0] coup_wa;

  logic [AW-1:0]         row_r;
  logic signed [31:0]    noise_r;
  logic [AW-1:0]         jcnt;
  logic [CAW-1:0]        caddr;
  logic [AW-1:0]         phase_ra;
  logic [PHASE_BITS-1:0] phase_q;
  logic [32:0]           freq_q;
  logic signed [15:0]    coup_q;
  logic [PHASE_BITS-1:0] phase_i;

  logic v1;
  logic v2;
  logic v3;

  logic [PHASE_BITS-1:0] dph;
  logic [OW-1:0]         offs;
  logic [OW+TW-1:0]      scaled;
  logic [TW-1:0]         idx;
  logic [TW-1:0]         rom_addr;
  logic [14:0]           mag;
  logic                  neg_d;
  logic signed [15:0]    coup_d;
  logic signed [15:0]    sine;
  logic signed [31:0]    prod_q;

  logic signed [47:0] acc;
  logic               sat;
  logic [47:0]        freq_ext;
  logic [47:0]        noise_ext;
  logic [48:0]        term_ext;
  logic [48:0]        sum;

  assign osc_ext  = 32'(item.osc_index);
  assign col_ext  = 32'(item.col_index);
  assign row_a    = osc_ext[AW-1:0];
  assign col_a    = col_ext[AW-1:0];
  assign row_base = CAW'(row_a) * CAW'(OSC_COUNT);
  assign coup_wa  = row_base + CAW'(col_a);

  // Stores: written on request transfer, read with registered data.
  always_ff @(posedge clk) begin
    if (rc.wr_phase) begin
      phase_mem[row_a] <= PHASE_BITS'(item.phase_value);
    end
    phase_q <= phase_mem[phase_ra];
  end

  always_ff @(posedge clk) begin
    if (rc.wr_freq) begin
      freq_mem[row_a] <= {item.fixed_flag, item.freq_value};
    end
    freq_q <= freq_mem[row_r];
  end

  always_ff @(posedge clk) begin
    if (rc.wr_coup) begin
      coup_mem[coup_wa] <= item.coupling_value;
    end
    coup_q <= coup_mem[caddr];
  end

  assign phase_ra = ctrl.fetch_row ? row_r : jcnt;

  // Walk counters.
  always_ff @(posedge clk) begin
    if (rc.start) begin
      row_r   <= row_a;
      noise_r <= item.noise_value;
      caddr   <= row_base;
    end else if (ctrl.issue) begin
      caddr <= caddr + CAW'(1);
    end
    if (ctrl.load_row) begin
      jcnt <= '0;
    end else if (ctrl.issue) begin
      jcnt <= jcnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= ctrl.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Phase difference to quadrant and table index.
  assign dph      = phase_q - phase_i;
  assign offs     = dph[OW-1:0];
  assign scaled   = (OW+TW)'(offs) * (OW+TW)'(SINE_TABLE_DEPTH);
  assign idx      = scaled[OW+TW-1:OW];
  assign rom_addr = dph[PHASE_BITS-2] ? (TW'(SINE_TABLE_DEPTH) - idx) : idx;

  kpd_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sine (
    .clk  (clk),
    .addr (rom_addr),
    .mag  (mag)
  );

  always_ff @(posedge clk) begin
    neg_d  <= dph[PHASE_BITS-1];
    coup_d <= coup_q;
  end

  assign sine = neg_d ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_ff @(posedge clk) begin
    prod_q <= coup_d * sine;
  end

  // Accumulate with 48-bit saturation; floor shift to Q16.16.
  assign freq_ext  = {{16{freq_q[31]}}, freq_q[31:0]};
  assign noise_ext = freq_q[32] ? 48'd0 : {{16{noise_r[31]}}, noise_r};
  assign term_ext  = {{17{prod_q[31]}}, prod_q};
  assign sum       = {acc[47], acc} + 49'($signed(term_ext) >>> 11);

  always_ff @(posedge clk) begin
    if (ctrl.load_row) begin
      phase_i <= phase_q;
      acc     <= freq_ext + noise_ext;
      sat     <= 1'b0;
    end else if (v3) begin
      if (sum[48] != sum[47]) begin
        acc <= sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        sat <= 1'b1;
      end else begin
        acc <= sum[47:0];
      end
    end
  end

  assign status.more_j = (jcnt != AW'(OSC_COUNT - 1));
  assign status.busy   = v1 || v2 || v3;
  assign phase_rate    = acc;
  assign saturated     = sat;

  `ASSERT_IMP(a_emit_drained, clk, rst, ctrl.load_out, !v1 && !v2 && !v3)

endmodule

@@ rtl/kuramoto_phase_derivative_unit.sv @@
// ---------------------------------------------------------------------------
// kuramoto_phase_derivative_unit
// Kuramoto phase derivative engine with a microcoded coupling walk.
// ---------------------------------------------------------------------------
// A write request (coupling, phase, or frequency with its fixed-pace flag)
// returns nothing. A compute request for oscillator i returns one result,
// freq[i] + noise (dropped when the flag is set) + the sum over j of
// coupling[i][j] * sin(phase[j] - phase[i]), saturated at 48 bits, and no
// request is taken until that result is in the output register. Besides
// fetch, pipeline fill and drain of the four-stage sine and multiply path,
// the walk does one multiply-accumulate per cycle over the coupling row,
// set by the single read port of the coupling store. A request whose
// osc_index (or col_index, for coupling writes) is not below OSC_COUNT is
// taken and dropped. A finished result sits in the output register, so the
// next request is taken while it waits.
// Read a phase, frequency or coupling entry only after writing it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kuramoto_phase_derivative_unit
  import kpd_pkg::*;
#(
  parameter int OSC_COUNT        = DEF_OSC_COUNT,
  parameter int PHASE_BITS       = DEF_PHASE_BITS,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic res_valid,
  input  logic res_stall,
  output res_t res_data
);

  ctrl_word_t  ctrl;
  seq_status_t seq_status;
  dp_status_t  dp_status;
  req_ctrl_t   rc;

  logic               req_xfer;
  logic [31:0]        osc_ext;
  logic [31:0]        col_ext;
  logic               row_ok;
  logic               col_ok;
  logic [5:0]         index_r;
  logic signed [47:0] acc_out;
  logic               sat_out;

  // Take requests only in the idle step of the program.
  assign req_stall = !ctrl.accept_en;
  assign req_xfer  = req_valid && !req_stall;

  // Out-of-range indexes drop the request.
  assign osc_ext = 32'(req_data.osc_index);
  assign col_ext = 32'(req_data.col_index);
  assign row_ok  = osc_ext < 32'(OSC_COUNT);
  assign col_ok  = col_ext < 32'(OSC_COUNT);

  assign rc.wr_coup  = req_xfer && row_ok && col_ok && (req_data.req_type == REQ_COUPLING);
  assign rc.wr_phase = req_xfer && row_ok && (req_data.req_type == REQ_PHASE);
  assign rc.wr_freq  = req_xfer && row_ok && (req_data.req_type == REQ_FREQ);
  assign rc.start    = req_xfer && row_ok && (req_data.req_type == REQ_COMPUTE);

  assign seq_status.compute_go = rc.start;
  assign seq_status.more_j     = dp_status.more_j;
  assign seq_status.busy       = dp_status.busy;
  assign seq_status.out_full   = res_valid;

  kpd_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (seq_status),
    .ctrl   (ctrl)
  );

  kpd_datapath #(
    .OSC_COUNT        (OSC_COUNT),
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .rc         (rc),
    .item       (req_data),
    .status     (dp_status),
    .phase_rate (acc_out),
    .saturated  (sat_out)
  );

  // Hold the index of the compute in flight.
  always_ff @(posedge clk) begin
    if (rc.start) begin
      index_r <= req_data.osc_index;
    end
  end

  // Output register: load on emit, drop valid after the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      res_data.result_index <= index_r;
      res_data.phase_rate   <= acc_out;
      res_data.saturated    <= sat_out;
    end
  end

  `ASSERT_IMP(a_emit_free, clk, rst, ctrl.load_out, !res_valid)
  `ASSERT_IMP(a_accept_quiet, clk, rst, req_valid && !req_stall, !dp_status.busy)

endmodule

@@ tb/kpd_rate_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kpd_rate_checker
// Watches both channels of the phase derivative unit, tracks the phase,
// frequency, fixed-pace and coupling stores, predicts every derivative and
// compares each result transfer field by field against the oldest one due.
// ---------------------------------------------------------------------------
module kpd_rate_checker
  import kpd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  input  logic  req_stall,
  input  req_t  req_data,
  input  logic  res_valid,
  input  logic  res_stall,
  input  res_t  res_data,
  output int    fail_count,
  output int    pending
);

  localparam int OSC_N   = DEF_OSC_COUNT;
  localparam int PH_BITS = DEF_PHASE_BITS;
  localparam int TAB_N   = DEF_SINE_TABLE_DEPTH;

  localparam longint RATE_MAX = (64'sd1 <<< 47) - 1;
  localparam longint RATE_MIN = -(64'sd1 <<< 47);

  int                  quarter_sine [0:TAB_N];
  logic [PH_BITS-1:0]  phase_mem [OSC_N];
  logic signed [31:0]  freq_mem [OSC_N];
  logic                fixed_mem [OSC_N];
  logic signed [15:0]  coup_mem [OSC_N][OSC_N];
  res_t                rate_due [$];

  // Quarter-wave sine in Q1.15 from a truncated Taylor series in Q2.30.
  initial begin : sine_build
    longint unsigned x, t;
    longint s, e;
    for (int k = 0; k <= TAB_N; k++) begin
      x = (64'd1686629713 * k) / TAB_N;
      t = x;
      s = longint'(x);
      for (int n = 1; n <= 12; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) s -= longint'(t);
        else s += longint'(t);
      end
      if (s < 0) s = 0;
      e = (s * 32767 + (64'sd1 <<< 29)) >>> 30;
      if (e > 32767) e = 32767;
      quarter_sine[k] = int'(e);
    end
  end

  function automatic void clamp48(inout longint a, inout bit sat);
    if (a > RATE_MAX) begin
      a = RATE_MAX;
      sat = 1'b1;
    end else if (a < RATE_MIN) begin
      a = RATE_MIN;
      sat = 1'b1;
    end
  endfunction

  function automatic res_t predict_rate(input logic [5:0] row,
                                        input logic signed [31:0] noise);
    res_t               r;
    longint             acc, p, term;
    logic [PH_BITS-1:0] d;
    int                 idx, sn;
    bit                 sat;
    sat = 1'b0;
    acc = longint'(freq_mem[row]);
    if (!fixed_mem[row]) acc += longint'(noise);
    clamp48(acc, sat);
    for (int j = 0; j < OSC_N; j++) begin
      d   = phase_mem[j] - phase_mem[row];
      idx = int'((longint'(d[PH_BITS-3:0]) * TAB_N) >> (PH_BITS - 2));
      if (idx >= TAB_N) idx = TAB_N - 1;
      sn = d[PH_BITS-2] ? quarter_sine[TAB_N-idx] : quarter_sine[idx];
      if (d[PH_BITS-1]) sn = -sn;
      p = longint'(coup_mem[row][j]) * sn;
      // Floor the Q5.27 product into Q16.16.
      term = (p >= 0) ? (p >>> 11) : -((-p + 2047) >>> 11);
      acc += term;
      clamp48(acc, sat);
    end
    r.result_index = row;
    r.phase_rate   = acc[47:0];
    r.saturated    = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      foreach (fixed_mem[i]) fixed_mem[i] = 1'b0;
      rate_due.delete();
      fail_count = 0;
    end else begin
      // Retire the result first: it can never belong to a request taken
      // at this same edge.
      if (res_valid && !res_stall) begin
        if (rate_due.size() == 0) begin
          fail_count++;
          $display("%0t: result with none due, expected nothing, got index %0d rate %0d sat %0b",
                   $time, res_data.result_index, res_data.phase_rate, res_data.saturated);
        end else begin
          want = rate_due.pop_front();
          if (res_data.result_index !== want.result_index) begin
            fail_count++;
            $display("%0t: result_index mismatch, expected %0d, got %0d",
                     $time, want.result_index, res_data.result_index);
          end
          if (res_data.phase_rate !== want.phase_rate) begin
            fail_count++;
            $display("%0t: phase_rate mismatch, expected %0d, got %0d",
                     $time, want.phase_rate, res_data.phase_rate);
          end
          if (res_data.saturated !== want.saturated) begin
            fail_count++;
            $display("%0t: saturated mismatch, expected %0b, got %0b",
                     $time, want.saturated, res_data.saturated);
          end
        end
      end
      if (req_valid && !req_stall) begin
        case (req_kind_t'(req_data.req_type))
          REQ_COUPLING:
            coup_mem[req_data.osc_index][req_data.col_index] = req_data.coupling_value;
          REQ_PHASE:   phase_mem[req_data.osc_index] = req_data.phase_value[PH_BITS-1:0];
          REQ_FREQ: begin
            freq_mem[req_data.osc_index]  = req_data.freq_value;
            fixed_mem[req_data.osc_index] = req_data.fixed_flag;
          end
          REQ_COMPUTE:
            rate_due.insert(rate_due.size(),
                            predict_rate(req_data.osc_index, req_data.noise_value));
          default: ;
        endcase
      end
    end
    pending = rate_due.size();
  end

endmodule

@@ tb/kuramoto_phase_derivative_unit_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kuramoto_phase_derivative_unit_tb
// Drives write and compute requests into the phase derivative unit with
// random idle cycles and result stalls, and lets the rate checker judge
// every result. Prints the verdict once all due results have arrived.
// ---------------------------------------------------------------------------
module kuramoto_phase_derivative_unit_tb;
  import kpd_pkg::*;

  // Longest span with no transfer on either channel before giving up.
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 310;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;

  int fail_count;
  int pending;
  int quiet_cycles = 0;

  // Idling switches for the two sides; cleared for a stretch of the run.
  bit req_idle_on = 1'b1;
  bit res_idle_on = 1'b1;

  always #5 clk = ~clk;

  kuramoto_phase_derivative_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  kpd_rate_checker rate_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Stall the result channel at random, about 23 percent of the time.
  always @(negedge clk) begin
    res_stall <= res_idle_on && ($urandom_range(99) < 23);
  end

  // Count cycles with no transfer at all; a hung block ends the run here.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Build a request of the given kind with random content, pulling values
  // to their extremes now and then.
  function automatic req_t rand_req(input req_kind_t kind);
    req_t         r;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    r.req_type = kind;
    case ($urandom_range(7))
      0: r.coupling_value = 16'sh8000;
      1: r.coupling_value = 16'sh7FFF;
      2: r.freq_value     = 32'sh8000_0000;
      3: r.freq_value     = 32'sh7FFF_FFFF;
      4: r.noise_value    = 32'sh8000_0000;
      5: r.noise_value    = 32'sh7FFF_FFFF;
      default: ;
    endcase
    return r;
  endfunction

  // Enter and leave at a falling edge; hold the payload until the transfer.
  task automatic put_request(input req_t r);
    while (req_idle_on && $urandom_range(99) < 23) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  initial begin
    req_t              r;
    logic [15:0]       edge_phase [6];
    logic [5:0]        live_row [4];
    int                pick;
    edge_phase = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h3FFF};
    live_row   = '{6'd0, 6'd1, 6'd2, 6'd63};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Preload every phase, and the frequency and whole coupling row of each
    // oscillator that is ever computed, so no compute reads an entry that
    // was never written.
    for (int i = 0; i < DEF_OSC_COUNT; i++) begin
      r = rand_req(REQ_PHASE);
      r.osc_index = 6'(i);
      put_request(r);
    end
    for (int k = 0; k < 4; k++) begin
      r = rand_req(REQ_FREQ);
      r.osc_index = live_row[k];
      put_request(r);
      for (int j = 0; j < DEF_OSC_COUNT; j++) begin
        r = rand_req(REQ_COUPLING);
        r.osc_index = live_row[k];
        r.col_index = 6'(j);
        put_request(r);
      end
    end

    // Directed: phases on quadrant boundaries and at both ends of the range.
    for (int k = 0; k < 6; k++) begin
      r = rand_req(REQ_PHASE);
      r.osc_index   = (k == 5) ? 6'd63 : 6'(k);
      r.phase_value = edge_phase[k];
      put_request(r);
    end
    // Extreme couplings in the first and last rows.
    r = rand_req(REQ_COUPLING);
    r.osc_index = 6'd0;  r.col_index = 6'd1;  r.coupling_value = 16'sh8000;
    put_request(r);
    r.col_index = 6'd63; r.coupling_value = 16'sh7FFF;
    put_request(r);
    r.osc_index = 6'd63; r.col_index = 6'd0;  r.coupling_value = 16'sh8000;
    put_request(r);
    r.col_index = 6'd63; r.coupling_value = 16'sh7FFF;
    put_request(r);
    // Largest frequency plus largest noise on a free-running oscillator.
    r = rand_req(REQ_FREQ);
    r.osc_index = 6'd0; r.freq_value = 32'sh7FFF_FFFF; r.fixed_flag = 1'b0;
    put_request(r);
    r = rand_req(REQ_COMPUTE);
    r.osc_index = 6'd0; r.noise_value = 32'sh7FFF_FFFF;
    put_request(r);
    // Metronome: the noise must be dropped.
    r = rand_req(REQ_FREQ);
    r.osc_index = 6'd63; r.freq_value = 32'sh8000_0000; r.fixed_flag = 1'b1;
    put_request(r);
    r = rand_req(REQ_COMPUTE);
    r.osc_index = 6'd63; r.noise_value = 32'sh7FFF_FFFF;
    put_request(r);
    // Most negative frequency plus most negative noise.
    r = rand_req(REQ_FREQ);
    r.osc_index = 6'd0; r.freq_value = 32'sh8000_0000; r.fixed_flag = 1'b0;
    put_request(r);
    r = rand_req(REQ_COMPUTE);
    r.osc_index = 6'd0; r.noise_value = 32'sh8000_0000;
    put_request(r);
    for (int k = 1; k < 3; k++) begin
      r = rand_req(REQ_COMPUTE);
      r.osc_index = live_row[k];
      put_request(r);
    end

    // Random mix, computes most often, with an idle-free stretch and one pause
    // that drains every due result before going on.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      req_idle_on = !(n >= 80 && n < 200);
      res_idle_on = req_idle_on;
      if (n == 240) begin
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        @(negedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        r = rand_req(REQ_COMPUTE);
        r.osc_index = live_row[$urandom_range(3)];
      end
      else if (pick < 75) r = rand_req(REQ_COUPLING);
      else if (pick < 87) r = rand_req(REQ_PHASE);
      else r = rand_req(REQ_FREQ);
      put_request(r);
    end
    req_valid <= 1'b0;

    // Drain, then give a stray result time to show up.
    while (pending != 0) @(negedge clk);
    repeat (DEF_OSC_COUNT + 20) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
